>>> src/psz_pkg.sv
`timescale 1ns / 1ps
package psz_pkg;

  // frame and splat geometry
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int MAX_SPLAT    = 6;
  localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(FRAME_PIXELS);
  localparam int XW           = $clog2(FRAME_WIDTH);
  localparam int YW           = $clog2(FRAME_HEIGHT);
  // signed pixel position before the frame test, holds -MAX_SPLAT .. size+MAX_SPLAT
  localparam int PW           = $clog2((FRAME_WIDTH > FRAME_HEIGHT ? FRAME_WIDTH : FRAME_HEIGHT)
                                       + MAX_SPLAT + 1) + 1;
  localparam int SW           = $clog2(MAX_SPLAT + 1);

  // arithmetic widths
  localparam int ACCW = 58;   // accumulators and numerators
  localparam int DENW = 38;   // perspective denominator
  localparam int CNTW = $clog2(ACCW);
  localparam int LAST_STEP = 14;

  localparam logic [31:0] DEPTH_FAR   = 32'h7FFF_FFFF;
  localparam logic [31:0] NEAR_FLOOR  = 32'd66;
  localparam logic [31:0] ORTHO_DEN   = 32'd65536;

  typedef struct packed {
    logic               func;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [23:0] pixel_color;
    logic        last_pixel;
  } result_t;

  typedef enum logic [2:0] {
    CFG_VIEW_ROT, CFG_CENTER, CFG_CLIP_LO, CFG_CLIP_HI,
    CFG_GAINS, CFG_CAM_DIST, CFG_ORIGIN, CFG_MODE
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CLIP, ST_CALC, ST_DIV, ST_RANGE, ST_READ, ST_TEST, ST_FLUSH
  } state_t;

  localparam logic FUNC_CLEAR = 1'b0;

endpackage

>>> src/psz_ram.sv
`timescale 1ns / 1ps
module psz_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/point_splat_zbuffer_rasterizer_unit.sv
`timescale 1ns / 1ps
// Z-buffered point splat rasterizer.
// Command channel: an item (cmd) is taken on a clock edge with start high and
// busy low. func clear resets the depth buffer; func draw clips, rotates and
// projects one point and depth-tests an s x s splat against the buffer.
// Result channel: each winning pixel appears on result for one cycle with
// result_valid high; the receiver cannot stall it. last_pixel marks the final
// pixel of an item. An item with no winner gives no result.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write registers only while busy is low.
// Sequence: a draw item runs the clip check, 15 calculation steps around one shared
// multiplier, two divisions (x, then y) on the bit-serial divider and the range check,
// then for each splat pixel a read and, if the pixel is in the frame, a test and write
// of the single-port depth memory, and at the end a flush.
// A clear item sweeps the 307200-entry depth memory at one entry per cycle.
// Reset: synchronous rst restores the control and config registers and starts the same
// clearing pass; busy is high until it ends.
module point_splat_zbuffer_rasterizer_unit
  import psz_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cmd_t        cmd,
  output logic        busy,
  output logic        result_valid,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // configuration
  logic [63:0] view_rotation, projection_gains;
  logic [47:0] cloud_center, clip_low_corner, clip_high_corner;
  logic [31:0] camera_distance, screen_origin;
  logic [3:0]  mode_and_splat;

  state_t state, state_next;
  cmd_t   pt;

  logic signed [16:0] d0, d1, d2;
  logic [3:0]         step;
  logic signed [ACCW-1:0] x1, y1, sya, dpa, nx, ny, qx, qy;
  logic [DENW-1:0]    den;

  logic [CNTW-1:0]    div_cnt;
  logic               div_y, div_neg;
  logic [ACCW-1:0]    div_n;
  logic [DENW-1:0]    div_rem;

  logic signed [PW-1:0] ixn, iyn;
  logic [SW-1:0]      dx, dy;
  logic [ADDR_W-1:0]  pix_addr, clr_addr;
  logic signed [31:0] dsat;
  logic               pend_v;
  result_t            pend;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [31:0]        mem_wdata, mem_rdata;

  psz_ram #(.WIDTH(32), .DEPTH(FRAME_PIXELS)) u_depth (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // splat size clamp
  logic [SW-1:0] splat;
  always_comb begin
    logic [2:0] raw;
    raw = mode_and_splat[3:1];
    if (raw < 3'd1) raw = 3'd1;
    if (raw > 3'd6) raw = 3'd6;
    splat = (SW'(raw) > SW'(MAX_SPLAT)) ? SW'(MAX_SPLAT) : SW'(raw);
  end

  // clip test and centering
  logic clip_ok;
  logic signed [16:0] c0, c1, c2;
  always_comb begin
    clip_ok = 1'b1;
    if (pt.point_x < $signed(clip_low_corner[15:0]) ||
        pt.point_x > $signed(clip_high_corner[15:0])) clip_ok = 1'b0;
    if (pt.point_y < $signed(clip_low_corner[31:16]) ||
        pt.point_y > $signed(clip_high_corner[31:16])) clip_ok = 1'b0;
    if (pt.point_z < $signed(clip_low_corner[47:32]) ||
        pt.point_z > $signed(clip_high_corner[47:32])) clip_ok = 1'b0;
    c0 = 17'(pt.point_x) - 17'($signed(cloud_center[15:0]));
    c1 = 17'(pt.point_y) - 17'($signed(cloud_center[31:16]));
    c2 = 17'(pt.point_z) - 17'($signed(cloud_center[47:32]));
  end

  // shared multiplier, operands picked by step
  logic signed [37:0] ma;
  logic signed [17:0] mb;
  logic signed [55:0] prod;
  logic signed [ACCW-1:0] pext, pshr, sxv, syv, depv, vd;
  logic signed [30:0] z1;
  logic [31:0] gain;
  logic signed [17:0] gh, gl;

  assign z1   = {d2, 14'b0};
  assign sxv  = x1 >>> 2;
  assign syv  = sya >>> 16;
  assign depv = dpa >>> 16;
  assign vd   = ACCW'($signed({1'b0, camera_distance})) + depv;
  assign gain = mode_and_splat[0] ? projection_gains[31:0] : projection_gains[63:32];
  assign gh   = $signed({2'b0, gain[31:16]});
  assign gl   = $signed({2'b0, gain[15:0]});

  always_comb begin
    ma = '0;
    mb = '0;
    case (step)
      4'd0:  begin ma = 38'(d0); mb = 18'($signed(view_rotation[15:0]));  end
      4'd1:  begin ma = 38'(d1); mb = 18'($signed(view_rotation[31:16])); end
      4'd2:  begin ma = 38'(d0); mb = 18'($signed(view_rotation[31:16])); end
      4'd3:  begin ma = 38'(d1); mb = 18'($signed(view_rotation[15:0]));  end
      4'd4:  begin ma = 38'(z1); mb = 18'($signed(view_rotation[47:32])); end
      4'd5:  begin ma = y1[37:0]; mb = 18'($signed(view_rotation[63:48])); end
      4'd6:  begin ma = y1[37:0]; mb = 18'($signed(view_rotation[47:32])); end
      4'd7:  begin ma = 38'(z1); mb = 18'($signed(view_rotation[63:48])); end
      4'd9:  begin ma = $signed(den); mb = 18'($signed(screen_origin[15:0])); end
      4'd10: begin ma = sxv[37:0]; mb = gh; end
      4'd11: begin ma = sxv[37:0]; mb = gl; end
      4'd12: begin ma = $signed(den); mb = 18'($signed(screen_origin[31:16])); end
      4'd13: begin ma = syv[37:0]; mb = gh; end
      4'd14: begin ma = syv[37:0]; mb = gl; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod = ma * mb;
  assign pext = ACCW'(prod);
  assign pshr = pext >>> 16;

  // divider step (restoring, one quotient bit a cycle)
  logic [DENW:0]  rem_sh;
  logic           rem_ge;
  logic [ACCW-1:0] quo_mag;
  logic signed [ACCW-1:0] quo_s, nx_mag, ny_mag;
  assign rem_sh  = {div_rem, div_n[ACCW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, den});
  assign quo_mag = {div_n[ACCW-2:0], rem_ge};
  assign quo_s   = div_neg ? -$signed(quo_mag) : $signed(quo_mag);
  assign nx_mag  = nx[ACCW-1] ? -nx : nx;
  assign ny_mag  = ny[ACCW-1] ? -ny : ny;
  logic div_done;
  assign div_done = (div_cnt == CNTW'(ACCW - 1));

  // frame range check
  logic range_ok;
  always_comb begin
    logic signed [ACCW-1:0] sv;
    sv = ACCW'($signed({1'b0, splat}));
    range_ok = !(qx < -sv || qy < -sv ||
                 qx >= ACCW'(FRAME_WIDTH) + sv || qy >= ACCW'(FRAME_HEIGHT) + sv);
  end

  // current splat pixel
  logic signed [PW-1:0] xx, yy;
  logic in_frame, pix_last, win;
  logic [ADDR_W-1:0] pix_addr_c;
  assign xx = ixn + PW'($signed({1'b0, dx}));
  assign yy = iyn + PW'($signed({1'b0, dy}));
  assign in_frame = (xx >= 0) && (xx < PW'(FRAME_WIDTH)) &&
                    (yy >= 0) && (yy < PW'(FRAME_HEIGHT));
  assign pix_addr_c = ADDR_W'(yy[YW-1:0] * ADDR_W'(FRAME_WIDTH)) + ADDR_W'(xx[XW-1:0]);
  assign pix_last = (dx == splat - 1'b1) && (dy == splat - 1'b1);
  assign win = (dsat < $signed(mem_rdata));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == ADDR_W'(FRAME_PIXELS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = (cmd.func == FUNC_CLEAR) ? ST_CLEAR : ST_CLIP;
      ST_CLIP:  state_next = clip_ok ? ST_CALC : ST_IDLE;
      ST_CALC:  if (step == 4'(LAST_STEP)) state_next = ST_DIV;
      ST_DIV:   if (div_done && div_y) state_next = ST_RANGE;
      ST_RANGE: state_next = range_ok ? ST_READ : ST_IDLE;
      ST_READ:  begin
        if (in_frame) state_next = ST_TEST;
        else if (pix_last) state_next = ST_FLUSH;
      end
      ST_TEST:  state_next = pix_last ? ST_FLUSH : ST_READ;
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = pix_addr;
    mem_wdata = dsat;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = DEPTH_FAR;
      end
      ST_READ:  mem_addr = pix_addr_c;
      ST_TEST:  mem_we = win;
      default:  mem_we = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      clr_addr         <= '0;
      pend_v           <= 1'b0;
      result_valid     <= 1'b0;
      view_rotation    <= '0;
      cloud_center     <= '0;
      clip_low_corner  <= '0;
      clip_high_corner <= '1;
      projection_gains <= '0;
      camera_distance  <= '0;
      screen_origin    <= '0;
      mode_and_splat   <= 4'd2;
    end else begin
      state        <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_VIEW_ROT: view_rotation    <= cfg_data;
          CFG_CENTER:   cloud_center     <= cfg_data[47:0];
          CFG_CLIP_LO:  clip_low_corner  <= cfg_data[47:0];
          CFG_CLIP_HI:  clip_high_corner <= cfg_data[47:0];
          CFG_GAINS:    projection_gains <= cfg_data;
          CFG_CAM_DIST: camera_distance  <= cfg_data[31:0];
          CFG_ORIGIN:   screen_origin    <= cfg_data[31:0];
          CFG_MODE:     mode_and_splat   <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == ST_IDLE) clr_addr <= '0;
      // hold back each winner until the next one shows whether it is last
      if (state == ST_TEST && win) pend_v <= 1'b1;
      else if (state == ST_FLUSH) pend_v <= 1'b0;
      result_valid <= pend_v && ((state == ST_TEST && win) || state == ST_FLUSH);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) pt <= cmd;
    if (state == ST_CLIP) begin
      d0   <= c0;
      d1   <= c1;
      d2   <= c2;
      step <= '0;
    end
    if (state == ST_CALC) begin
      step <= step + 1'b1;
      case (step)
        4'd0:  x1  <= pext;
        4'd1:  x1  <= x1 - pext;
        4'd2:  y1  <= pext;
        4'd3:  y1  <= y1 + pext;
        4'd4:  sya <= pext;
        4'd5:  sya <= sya - pext;
        4'd6:  dpa <= pext;
        4'd7:  dpa <= dpa + pext;
        4'd8:  begin
          if (mode_and_splat[0]) den <= DENW'(ORTHO_DEN);
          else if (vd < $signed(ACCW'(NEAR_FLOOR))) den <= DENW'(NEAR_FLOOR);
          else den <= vd[DENW-1:0];
          if (depv > ACCW'(32'sh7FFF_FFFF)) dsat <= 32'sh7FFF_FFFF;
          else if (depv < -ACCW'(64'sh8000_0000)) dsat <= 32'sh8000_0000;
          else dsat <= depv[31:0];
        end
        4'd9:  nx <= pext;
        4'd10: nx <= nx + pext;
        4'd11: nx <= nx + pshr;
        4'd12: ny <= pext;
        4'd13: ny <= ny - pext;
        4'd14: ny <= ny - pshr;
        default: ;
      endcase
      if (step == 4'(LAST_STEP)) begin
        div_n   <= nx_mag;
        div_neg <= nx[ACCW-1];
        div_rem <= '0;
        div_cnt <= '0;
        div_y   <= 1'b0;
      end
    end
    if (state == ST_DIV) begin
      if (div_done) begin
        div_cnt <= '0;
        div_rem <= '0;
        if (!div_y) begin
          qx      <= quo_s;
          div_n   <= ny_mag;
          div_neg <= ny[ACCW-1];
          div_y   <= 1'b1;
        end else begin
          qy <= quo_s;
        end
      end else begin
        div_rem <= rem_ge ? DENW'(rem_sh - {1'b0, den}) : rem_sh[DENW-1:0];
        div_n   <= quo_mag;
        div_cnt <= div_cnt + 1'b1;
      end
    end
    if (state == ST_RANGE) begin
      ixn <= qx[PW-1:0];
      iyn <= qy[PW-1:0];
      dx  <= '0;
      dy  <= '0;
    end
    if (state == ST_READ) pix_addr <= pix_addr_c;
    // advance through the splat
    if ((state == ST_READ && !in_frame) || state == ST_TEST) begin
      if (dx == splat - 1'b1) begin
        dx <= '0;
        dy <= dy + 1'b1;
      end else begin
        dx <= dx + 1'b1;
      end
    end
    if (state == ST_TEST && win) begin
      pend.pixel_x     <= 10'(xx[XW-1:0]);
      pend.pixel_y     <= 9'(yy[YW-1:0]);
      pend.pixel_color <= {pt.red, pt.green, pt.blue};
      pend.last_pixel  <= 1'b0;
      result           <= pend;
    end else if (state == ST_FLUSH) begin
      result <= {pend.pixel_x, pend.pixel_y, pend.pixel_color, 1'b1};
    end
  end

  // checks
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == ST_TEST || $past(state) == ST_FLUSH))
    else $error("result without a test or flush");
  a_we_src: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || state == ST_TEST))
    else $error("depth write outside clear or test");
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_pixel) |=> !result_valid)
    else $error("result after last pixel");
  a_idle_pend: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !pend_v)
    else $error("pending pixel while idle");

endmodule

>>> tb/sv/point_splat_zbuffer_rasterizer_unit_tb.sv
`timescale 1ns / 1ps
module point_splat_zbuffer_rasterizer_unit_tb;
  import psz_pkg::*;

  localparam int STALL_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start;
  cmd_t        cmd;
  logic        busy;
  logic        result_valid;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  point_splat_zbuffer_rasterizer_unit u_top (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // shadow of the block's registers and depth buffer
  logic [63:0] rot_m    = '0;
  logic [47:0] center_m = '0;
  logic [47:0] clip_lo  = '0;
  logic [47:0] clip_hi  = 48'hFFFF_FFFF_FFFF;
  logic [63:0] gains_m  = '0;
  logic [31:0] cam_m    = '0;
  logic [31:0] origin_m = '0;
  logic [3:0]  mode_m   = 4'd2;
  int          zbuf[FRAME_PIXELS];

  cmd_t    pending_q[$];
  result_t pixel_q[$];
  int      pushed_n = 0;
  int      accepted_n = 0;
  int      errors = 0;
  int      idle_cycles = 0;
  int      burst_left = 1;
  int      gap_left = 0;

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint lane(input logic [63:0] w, input int k);
    logic [15:0] v;
    v = w[16*k +: 16];
    return longint'($signed(v));
  endfunction

  function automatic longint scale_by(input longint a, input logic [31:0] g);
    longint gh, gl;
    gh = longint'({48'b0, g[31:16]});
    gl = longint'({48'b0, g[15:0]});
    return a * gh + ((a * gl) >>> 16);
  endfunction

  function automatic void wipe_depth();
    foreach (zbuf[i]) zbuf[i] = int'(DEPTH_FAR);
  endfunction

  // clear the depth shadow, or clip, rotate, project and depth-test one item; queue the winning pixels
  function automatic void rasterize_point(input cmd_t c);
    longint p[3], d[3], cyw, syw, cpi, spi, x1, y1, z1, sx, sy, dep;
    longint den, numx, numy, ix, iy, s, xx, yy;
    logic [31:0] g;
    int dsat;
    result_t r;
    result_t won[$];
    if (c.func == FUNC_CLEAR) begin
      wipe_depth();
      return;
    end
    p[0] = longint'(c.point_x);
    p[1] = longint'(c.point_y);
    p[2] = longint'(c.point_z);
    for (int a = 0; a < 3; a++) begin
      if (p[a] < lane(clip_lo, a) || p[a] > lane(clip_hi, a)) return;
      d[a] = p[a] - lane(center_m, a);
    end
    cyw = lane(rot_m, 0);
    syw = lane(rot_m, 1);
    cpi = lane(rot_m, 2);
    spi = lane(rot_m, 3);
    x1 = d[0] * cyw - d[1] * syw;
    y1 = d[0] * syw + d[1] * cyw;
    z1 = d[2] * 16384;
    sx = x1 >>> 2;
    sy = (z1 * cpi - y1 * spi) >>> 16;
    dep = (y1 * cpi + z1 * spi) >>> 16;
    if (mode_m[0]) begin
      g = gains_m[31:0];
      den = 65536;
    end else begin
      g = gains_m[63:32];
      den = longint'({32'b0, cam_m}) + dep;
      if (den < 66) den = 66;
    end
    numx = lane(origin_m, 0) * den + scale_by(sx, g);
    numy = lane(origin_m, 1) * den - scale_by(sy, g);
    ix = numx / den;
    iy = numy / den;
    if (dep > 64'sd2147483647) dsat = 32'h7FFF_FFFF;
    else if (dep < -64'sd2147483648) dsat = 32'h8000_0000;
    else dsat = int'(dep);
    s = longint'(mode_m[3:1]);
    if (s < 1) s = 1;
    if (s > 6) s = 6;
    if (s > MAX_SPLAT) s = MAX_SPLAT;
    if (ix < -s || iy < -s || ix >= FRAME_WIDTH + s || iy >= FRAME_HEIGHT + s) return;
    for (longint dy = 0; dy < s; dy++) begin
      yy = iy + dy;
      if (yy < 0 || yy >= FRAME_HEIGHT) continue;
      for (longint dx = 0; dx < s; dx++) begin
        xx = ix + dx;
        if (xx < 0 || xx >= FRAME_WIDTH) continue;
        if (dsat < zbuf[yy * FRAME_WIDTH + xx]) begin
          zbuf[yy * FRAME_WIDTH + xx] = dsat;
          r.pixel_x = xx[9:0];
          r.pixel_y = yy[8:0];
          r.pixel_color = {c.red, c.green, c.blue};
          r.last_pixel = 1'b0;
          won = {won, r};
        end
      end
    end
    if (won.size() > 0) won[won.size() - 1].last_pixel = 1'b1;
    foreach (won[i]) pixel_q = {pixel_q, won[i]};
  endfunction

  // item acceptance, register shadowing, result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        rasterize_point(pending_q.pop_front());
        accepted_n++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 6);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 400)
                                                 : $urandom_range(0, 4);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_VIEW_ROT: rot_m    = cfg_data;
          CFG_CENTER:   center_m = cfg_data[47:0];
          CFG_CLIP_LO:  clip_lo  = cfg_data[47:0];
          CFG_CLIP_HI:  clip_hi  = cfg_data[47:0];
          CFG_GAINS:    gains_m  = cfg_data;
          CFG_CAM_DIST: cam_m    = cfg_data[31:0];
          CFG_ORIGIN:   origin_m = cfg_data[31:0];
          CFG_MODE:     mode_m   = cfg_data[3:0];
          default: ;
        endcase
      end
      if (result_valid) begin
        if (pixel_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected pixel %0d,%0d", result.pixel_x, result.pixel_y));
        end else begin
          result_t e;
          e = pixel_q.pop_front();
          if (result.pixel_x !== e.pixel_x)
            flag_mismatch($sformatf("pixel_x %0d exp %0d", result.pixel_x, e.pixel_x));
          if (result.pixel_y !== e.pixel_y)
            flag_mismatch($sformatf("pixel_y %0d exp %0d", result.pixel_y, e.pixel_y));
          if (result.pixel_color !== e.pixel_color)
            flag_mismatch($sformatf("color %h exp %h", result.pixel_color, e.pixel_color));
          if (result.last_pixel !== e.last_pixel)
            flag_mismatch($sformatf("last_pixel %b exp %b", result.last_pixel, e.last_pixel));
        end
      end
    end
    if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // item driver: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending_q.size() > 0) begin
      start <= 1'b1;
      cmd <= pending_q[0];
    end else begin
      start <= 1'b0;
    end
  end

  task automatic push_item(input logic fn, input int x, input int y, input int z);
    cmd_t c;
    c.func = fn;
    c.point_x = 16'(x);
    c.point_y = 16'(y);
    c.point_z = 16'(z);
    c.red = 8'($urandom);
    c.green = 8'($urandom);
    c.blue = 8'($urandom);
    pending_q = {pending_q, c};
    pushed_n++;
  endtask

  task automatic push_random_point();
    if ($urandom_range(0, 4) == 0)
      push_item(1'b1, int'($urandom), int'($urandom), int'($urandom));
    else
      push_item(1'b1, $urandom_range(0, 960) - 480, $urandom_range(0, 960) - 480,
                $urandom_range(0, 960) - 480);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (!(accepted_n == pushed_n && !busy && pixel_q.size() == 0));
  endtask

  function automatic logic [31:0] trig_pair(input real deg);
    real rad;
    rad = deg * 3.14159265358979 / 180.0;
    return {16'($rtoi(16384.0 * $sin(rad))), 16'($rtoi(16384.0 * $cos(rad)))};
  endfunction

  // usable viewing setup with random rotation, gains and splat size
  task automatic sane_setup(input logic ortho, input int s);
    write_reg(CFG_VIEW_ROT, {trig_pair($urandom_range(0, 359)),
                             trig_pair($urandom_range(0, 359))});
    write_reg(CFG_CENTER, {16'($urandom_range(0, 64) - 32), 16'($urandom_range(0, 64) - 32),
                           16'($urandom_range(0, 64) - 32)});
    write_reg(CFG_CLIP_LO, {3{16'(-480)}});
    write_reg(CFG_CLIP_HI, {3{16'(480)}});
    write_reg(CFG_GAINS, {16'($urandom_range(200, 500)), 16'($urandom),
                          16'($urandom_range(5, 15)), 16'($urandom)});
    write_reg(CFG_CAM_DIST, {16'($urandom_range(35, 60)), 16'($urandom)});
    write_reg(CFG_ORIGIN, {16'($urandom_range(200, 280)), 16'($urandom_range(280, 360))});
    write_reg(CFG_MODE, {s[2:0], ortho});
  endtask

  initial begin
    int n_items;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    wipe_depth();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait_drained();

    // reset setup has an inverted clip box: everything is dropped
    push_item(1'b1, 0, 0, 0);
    push_item(1'b1, -1, -1, -1);
    wait_drained();

    // orthographic, identity rotation, 10 px/m, one-pixel splat
    write_reg(CFG_VIEW_ROT, {16'd0, 16'd16384, 16'd0, 16'd16384});
    write_reg(CFG_CENTER, '0);
    write_reg(CFG_CLIP_LO, {3{16'(-480)}});
    write_reg(CFG_CLIP_HI, {3{16'(480)}});
    write_reg(CFG_GAINS, {32'd0, 32'd10 << 16});
    write_reg(CFG_CAM_DIST, '0);
    write_reg(CFG_ORIGIN, {16'd240, 16'd320});
    write_reg(CFG_MODE, 64'd3);
    push_item(1'b1, 0, 0, 0);
    push_item(1'b1, 0, 0, 0);          // equal depth keeps the old entry
    push_item(1'b1, 0, -16, 0);        // nearer wins
    push_item(1'b1, 0, 16, 0);         // farther loses
    push_item(1'b1, 480, 480, 480);    // on the clip bound, off screen
    push_item(1'b1, -480, 0, 0);
    push_item(1'b1, 481, 0, 0);        // just outside the clip box
    push_item(1'b1, 32767, -32768, 0);
    push_item(1'b1, -32768, 32767, -32768);
    push_item(1'b1, 0, 0, 384);
    push_item(1'b1, 0, 0, -383);
    push_item(FUNC_CLEAR, 0, 0, 0);
    push_item(1'b1, 0, 16, 0);         // wins again after the clear
    wait_drained();

    // largest splat, edges of the frame
    write_reg(CFG_GAINS, {32'd0, 32'd694682});
    write_reg(CFG_ORIGIN, {16'd240, 16'd316});
    write_reg(CFG_MODE, 64'd13);
    push_item(1'b1, 0, -32, 0);
    push_item(1'b1, 480, 0, 0);
    push_item(1'b1, -480, 0, 0);
    push_item(1'b1, 0, 0, 480);
    push_item(1'b1, 0, 0, -480);
    wait_drained();

    // perspective with no camera distance: near floor takes over
    write_reg(CFG_VIEW_ROT, {16'd0, 16'd16384, 16'd16384, 16'd0});
    write_reg(CFG_GAINS, {32'd300 << 16, 32'd0});
    write_reg(CFG_MODE, 64'd4);
    push_item(1'b1, 0, 16, 0);
    push_item(1'b1, 0, -16, 0);
    push_item(1'b1, 16, 0, 16);
    push_item(1'b1, -48, 32, -16);
    wait_drained();

    // random phases
    n_items = 0;
    for (int ph = 0; n_items < 380; ph++) begin
      int k;
      k = (ph < 2) ? 10 : 40;
      if (ph == 0) begin
        for (int r = 0; r < 8; r++) write_reg(cfg_idx_t'(r), '1);
      end else if (ph == 1) begin
        sane_setup(1'b0, 0);
        write_reg(CFG_VIEW_ROT, '0);
        write_reg(CFG_CENTER, '0);
        write_reg(CFG_GAINS, '0);
        write_reg(CFG_CAM_DIST, '1);
        write_reg(CFG_ORIGIN, '0);
      end else if ($urandom_range(0, 4) == 0) begin
        for (int r = 0; r < 8; r++) write_reg(cfg_idx_t'(r), {$urandom, $urandom});
      end else begin
        sane_setup(1'($urandom), $urandom_range(0, 7));
      end
      for (int i = 0; i < k; i++) push_random_point();
      n_items += k;
      wait_drained();
    end

    repeat (400) @(posedge clk);
    if (pixel_q.size() != 0) flag_mismatch($sformatf("%0d pixels never seen", pixel_q.size()));
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
